// File: src/fbf_pkg.sv
// ============================================================================
// fbf_pkg
// Shared constants and coefficient helpers for the 63-tap bandpass FIR.
// ============================================================================
package fbf_pkg;

    localparam int DEFAULT_TAPS      = 63;
    localparam int DEFAULT_FRAC_BITS = 15;
    localparam int SAMPLE_W          = 16;
    localparam int COEFF_COUNT       = 63;
    localparam longint E7_SCALE      = 64'sd10000000;

    // Symmetric bandpass prototype, in units of 1e-7
    localparam int COEFF_E7 [COEFF_COUNT] = '{
        -448093,  322875,  181163,   87615,   56797,
          86685,  148049,  187190,  151019,   27594,
        -132676, -232561, -187804,    6382,  250536,
         387214,  299817,    2609, -345546, -525282,
        -395620,     246,  440998,  651867,  479110,
            135, -508558, -736313, -529380,    -709,
         540186,  766746,  540186,    -709, -529380,
        -736313, -508558,     135,  479110,  651867,
         440998,     246, -395620, -525282, -345546,
           2609,  299817,  387214,  250536,    6382,
        -187804, -232561, -132676,   27594,  151019,
         187190,  148049,   86685,   56797,   87615,
         181163,  322875, -448093
    };

    // Fixed-point weight: round to nearest, halves away from zero
    function automatic longint coeff_weight(input int idx, input int frac_bits);
        longint c;
        longint mag;
        longint q;
        c   = longint'(COEFF_E7[idx]);
        mag = (c < 0) ? -c : c;
        q   = ((mag << frac_bits) + (E7_SCALE / 2)) / E7_SCALE;
        return (c < 0) ? -q : q;
    endfunction

endpackage

// File: src/fbf_ram.sv
// ============================================================================
// fbf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module fbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 62,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/fir_bandpass_filter_63tap.sv
// ============================================================================
// fir_bandpass_filter_63tap
// Direct-form bandpass FIR with one shared multiply-accumulate over a history RAM.
// ============================================================================
// Usage:
//   Input stream: s_tdata[15:0] carries a signed sample, s_tlast marks the
//   end of a software block. Output stream: m_tdata[15:0] carries the filtered
//   sample, saturated to signed 16 bits, and m_tlast repeats the input tlast.
//   Every input transfer yields exactly one output transfer, in order.
//   The single multiplier walks one tap per cycle, reading the history RAM
//   one entry ahead; the drain state empties the product register into the
//   sum and writes the new sample, and the output state truncates toward
//   zero and saturates. The next item is accepted as soon as the result sits
//   in the output register; no new sample is taken while one is still being
//   filtered. If the receiver stalls, the result waits in the output
//   register; a further item runs but holds before loading it.
//   Reset: the history reads as all zero (per-entry valid bits cleared),
//   no output is pending, and s_tready is high right after reset.
// ============================================================================
module fir_bandpass_filter_63tap #(
    parameter int TAPS            = fbf_pkg::DEFAULT_TAPS,
    parameter int COEFF_FRAC_BITS = fbf_pkg::DEFAULT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tlast
);

    import fbf_pkg::*;

    localparam int HL  = TAPS - 1;
    localparam int AW  = (HL > 1) ? $clog2(HL) : 1;
    localparam int KW  = $clog2(TAPS);
    localparam int WW  = COEFF_FRAC_BITS + 1;
    localparam int PW  = SAMPLE_W + WW;
    localparam int ACW = PW + KW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    // Coefficient ROM
    logic signed [WW-1:0] tap_rom [TAPS];

    for (genvar g = 0; g < TAPS; g++)
    begin : g_rom
        if (g < COEFF_COUNT)
        begin : g_coef
            assign tap_rom[g] = WW'(coeff_weight(g, COEFF_FRAC_BITS));
        end
        else
        begin : g_zero
            assign tap_rom[g] = '0;
        end
    end

    state_t                      state_reg, state_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [AW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [HL-1:0]               hist_valid_reg, hist_valid_next;
    logic                        rd_vld_reg;
    logic                        prod_vld_reg, prod_vld_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic                        last_reg, last_next;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic signed [ACW-1:0]       acc_reg, acc_next;
    logic [15:0]                 out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic [SAMPLE_W-1:0]         rd_data;
    logic                        ram_we;
    logic signed [SAMPLE_W-1:0]  operand;
    logic signed [ACW-1:0]       biased;
    logic signed [ACW-1:0]       quot;
    logic [15:0]                 sat_val;
    logic [AW-1:0]               head_inc;

    fbf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HL),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_inc),
        .wdata (x_reg),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign head_inc = (head_reg == AW'(HL - 1)) ? '0 : head_reg + 1'b1;
    assign ram_we   = (state_reg == S_DRAIN);

    // Tap zero uses the incoming sample, later taps the history read
    assign operand = (k_reg == '0) ? x_reg :
                     (rd_vld_reg ? $signed(rd_data) : '0);

    // Truncate toward zero, then clamp
    assign biased = acc_reg[ACW-1] ? acc_reg + ACW'((64'd1 << COEFF_FRAC_BITS) - 1) : acc_reg;
    assign quot   = biased >>> COEFF_FRAC_BITS;

    always_comb
    begin
        if (quot > ACW'(32767))
        begin
            sat_val = 16'h7FFF;
        end
        else if (quot < -ACW'(32768))
        begin
            sat_val = 16'h8000;
        end
        else
        begin
            sat_val = quot[15:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        rd_ptr_next     = rd_ptr_reg;
        head_next       = head_reg;
        hist_valid_next = hist_valid_reg;
        prod_vld_next   = prod_vld_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next        = $signed(s_tdata);
                    last_next     = s_tlast;
                    k_next        = '0;
                    rd_ptr_next   = head_reg;
                    acc_next      = '0;
                    prod_vld_next = 1'b0;
                    state_next    = S_MAC;
                end
            end
            S_MAC:
            begin
                prod_next     = tap_rom[k_reg] * operand;
                prod_vld_next = 1'b1;
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + ACW'(prod_reg);
                end
                // Advance the read one entry older, wrapping around the ring
                rd_ptr_next = (rd_ptr_reg == '0) ? AW'(HL - 1) : rd_ptr_reg - 1'b1;
                if (k_reg == KW'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                acc_next                  = acc_reg + ACW'(prod_reg);
                prod_vld_next             = 1'b0;
                head_next                 = head_inc;
                hist_valid_next[head_inc] = 1'b1;
                state_next                = S_OUT;
            end
            S_OUT:
            begin
                // Hold the result until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = sat_val;
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            rd_ptr_reg     <= '0;
            head_reg       <= '0;
            hist_valid_reg <= '0;
            rd_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            rd_ptr_reg     <= rd_ptr_next;
            head_reg       <= head_next;
            hist_valid_reg <= hist_valid_next;
            rd_vld_reg     <= hist_valid_reg[rd_ptr_reg];
            prod_vld_reg   <= prod_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: src/fbf_checker.sv
// ============================================================================
// fbf_checker
// Port-level checks for the bandpass FIR, bound to the top level.
// ============================================================================
module fbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled output transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed during stall");

    // An accepted sample keeps the filter busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A new result only appears at the end of a busy period
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    // A result is loaded together with the return to ready
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("filter went ready without a result");

endmodule

bind fir_bandpass_filter_63tap fbf_checker u_fbf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb_fir_bandpass_filter_63tap.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_fir_bandpass_filter_63tap
// Self-checking stream testbench for the 63-tap bandpass FIR.
// Feeds directed extremes and then random audio-like segments such as noise, 1 kHz
// tones, full-scale sign-matched bursts that drive the sum into saturation.
// Both sides of the stream idle at random. A scoreboard keeps a bit-exact
// model of the filter and compares every output transfer in order.
// ============================================================================
module tb_fir_bandpass_filter_63tap;

    localparam int NUM_TAPS     = 63;
    localparam int HIST_DEPTH   = NUM_TAPS - 1;
    localparam int FRAC_BITS    = 15;
    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 500;

    // Prototype coefficients in units of 1e-7
    localparam int PROTO_E7 [NUM_TAPS] = '{
        -448093,  322875,  181163,   87615,   56797,
          86685,  148049,  187190,  151019,   27594,
        -132676, -232561, -187804,    6382,  250536,
         387214,  299817,    2609, -345546, -525282,
        -395620,     246,  440998,  651867,  479110,
            135, -508558, -736313, -529380,    -709,
         540186,  766746,  540186,    -709, -529380,
        -736313, -508558,     135,  479110,  651867,
         440998,     246, -395620, -525282, -345546,
           2609,  299817,  387214,  250536,    6382,
        -187804, -232561, -132676,   27594,  151019,
         187190,  148049,   86685,   56797,   87615,
         181163,  322875, -448093
    };

    // One period of a 1 kHz sine at 8 kHz sampling
    localparam int TONE_1K [8] = '{0, 23170, 32767, 23170, 0, -23170, -32767, -23170};

    typedef struct packed {
        logic [15:0] sample;
        logic        block_end;
    } audio_item_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] sample_in
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] sample_out
    logic        m_tlast;

    audio_item_t sample_feed [$];
    audio_item_t filtered_q [$];

    longint             tap_w [NUM_TAPS];
    logic signed [15:0] hist [HIST_DEPTH];

    int  samples_in   = 0;
    int  samples_out  = 0;
    int  errors       = 0;
    int  sat_hi       = 0;
    int  sat_lo       = 0;
    int  idle_cycles  = 0;
    int  hold_cnt     = 0;
    bit  hold_done    = 0;
    bit  in_taken     = 0;

    fir_bandpass_filter_63tap u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q0.15 weights, rounded to nearest with halves away from zero
    function automatic void load_tap_weights();
        longint mag;
        longint q;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            mag = (PROTO_E7[k] < 0) ? -longint'(PROTO_E7[k]) : longint'(PROTO_E7[k]);
            q   = (mag * (longint'(1) << FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
            tap_w[k] = (PROTO_E7[k] < 0) ? -q : q;
        end
        for (int k = 0; k < HIST_DEPTH; k++)
            hist[k] = '0;
    endfunction

    // Filter one new sample: exact sum, truncate toward zero, saturate
    function automatic logic [15:0] bandpass_output(input logic [15:0] x);
        longint acc;
        longint mag;
        logic [15:0] y;
        acc = tap_w[0] * longint'($signed(x));
        for (int k = 1; k < NUM_TAPS; k++)
            acc += tap_w[k] * longint'(hist[k-1]);
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            hist[k] = hist[k-1];
        hist[0] = $signed(x);
        if (acc < 0)
        begin
            mag = (-acc) >>> FRAC_BITS;
            y   = (mag > 32768) ? 16'h8000 : 16'(-mag);
        end
        else
        begin
            mag = acc >>> FRAC_BITS;
            y   = (mag > 32767) ? 16'h7FFF : 16'(mag);
        end
        return y;
    endfunction

    function automatic void add_sample(input int v, input logic last);
        audio_item_t it;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        it.sample    = 16'(v);
        it.block_end = last;
        sample_feed.push_back(it);
    endfunction

    function automatic void build_directed();
        add_sample(0, 1'b0);
        add_sample(32767, 1'b0);
        add_sample(-32768, 1'b1);
        add_sample(1, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(16'h5555, 1'b0);
        add_sample(-21846, 1'b1);         // 0xAAAA
        for (int i = 0; i < 4; i++)
            add_sample(32767, i == 3);
        for (int i = 0; i < 4; i++)
            add_sample(-32768, i == 3);
        for (int i = 0; i < 8; i++)
            add_sample((TONE_1K[i] >= 0) ? 32767 : -32768, i == 7);
    endfunction

    function automatic void build_random();
        int kind;
        int len;
        int amp;
        int v;
        bit neg;
        int base;
        base = sample_feed.size();
        while (sample_feed.size() - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    len = $urandom_range(10, 40);
                    for (int i = 0; i < len; i++)
                        add_sample(int'($signed(16'($urandom))),
                                   (i == len - 1) || ($urandom_range(0, 7) == 0));
                end
                3, 4:
                begin
                    // 1 kHz tone, sine or square, sits in the passband
                    len = $urandom_range(16, 64);
                    amp = $urandom_range(1000, 32767);
                    neg = ($urandom_range(0, 1) == 1);
                    for (int i = 0; i < len; i++)
                    begin
                        if (neg)
                            v = (TONE_1K[i % 8] >= 0) ? amp : -amp - 1;
                        else
                            v = TONE_1K[i % 8] * amp / 32767;
                        v += int'($urandom_range(0, 128)) - 64;
                        add_sample(v, i == len - 1);
                    end
                end
                5:
                begin
                    // Signs matched to the taps push the sum far past full scale
                    neg = ($urandom_range(0, 1) == 1);
                    for (int j = 0; j < NUM_TAPS; j++)
                        add_sample(((PROTO_E7[j] < 0) ^ neg) ? -32768 : 32767,
                                   j == NUM_TAPS - 1);
                end
                6:
                begin
                    len = $urandom_range(8, 32);
                    for (int i = 0; i < len; i++)
                        add_sample(int'($urandom_range(0, 510)) - 255,
                                   $urandom_range(0, 1) == 1);
                end
                7:
                begin
                    len = $urandom_range(8, 32);
                    for (int i = 0; i < len; i++)
                    begin
                        case ($urandom_range(0, 4))
                            0: v = -32768;
                            1: v = 32767;
                            2: v = -1;
                            3: v = 0;
                            default: v = 1;
                        endcase
                        add_sample(v, $urandom_range(0, 3) == 0);
                    end
                end
                default:
                begin
                    len = $urandom_range(8, 40);
                    v   = int'($urandom_range(0, 65535)) - 32768;
                    for (int i = 0; i < len; i++)
                        add_sample(v, i == len - 1);
                end
            endcase
        end
    endfunction

    // Scoreboard: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected output: expected none, got %0d last=%0b",
                             $time, $signed(m_tdata), m_tlast);
                    errors++;
                end
                else
                begin
                    automatic audio_item_t want = filtered_q.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $display("%0t: sample_out mismatch: expected %0d, got %0d",
                                 $time, $signed(want.sample), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tlast !== want.block_end)
                    begin
                        $display("%0t: block_end_out mismatch: expected %0b, got %0b",
                                 $time, want.block_end, m_tlast);
                        errors++;
                    end
                    if (want.sample == 16'h7FFF)
                        sat_hi++;
                    if (want.sample == 16'h8000)
                        sat_lo++;
                end
                samples_out++;
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken)
            begin
                automatic audio_item_t res;
                res.sample    = bandpass_output(s_tdata);
                res.block_end = s_tlast;
                filtered_q.push_back(res);
                samples_in++;
            end
        end
    end

    // Source: hold an offered item until it transfers, then maybe idle
    always @(negedge clk)
    begin
        automatic int idle_pct;
        automatic audio_item_t nxt;
        idle_pct = (samples_in < 300) ? 10 : (samples_in < 600) ? 84 : 0;
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (sample_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                nxt = sample_feed.pop_front();
                s_tdata  <= nxt.sample;
                s_tlast  <= nxt.block_end;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: random back-pressure plus one long hold-off to fill the pipe
    always @(negedge clk)
    begin
        automatic int stall_pct;
        stall_pct = (samples_in < 300) ? 84 : (samples_in < 600) ? 10 : 0;
        if (!hold_done && samples_in >= 650)
        begin
            hold_cnt  = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results still due",
                         $time, STALL_LIMIT, filtered_q.size());
                $display("fir_bandpass_filter_63tap verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        load_tap_weights();
        build_directed();
        build_random();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (sample_feed.size() != 0 || s_tvalid)
            @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d samples in, %0d filtered samples out, %0d errors.",
                 samples_in, samples_out, errors);
        $display("Outputs clipped high %0d times, low %0d times; one long sink hold-off.",
                 sat_hi, sat_lo);
        if (errors == 0)
            $display("fir_bandpass_filter_63tap verification clean");
        else
            $display("fir_bandpass_filter_63tap verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/fbf_pkg.sv
src/fbf_ram.sv
src/fir_bandpass_filter_63tap.sv
src/fbf_checker.sv
tb/sv/tb_fir_bandpass_filter_63tap.sv
